// ===== rtl/core/pitt_pkg.sv =====
`default_nettype none

package pitt_pkg;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_IPI    = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [15:0] irq;
        logic [15:0] interval;
        logic [15:0] countdown;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/pitt_in_if.sv =====
`default_nettype none

interface pitt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] irq_number;
    logic [15:0] poll_interval;
    logic        poll_enable;

    modport source (
        output valid, op, irq_number, poll_interval, poll_enable,
        input  ready
    );
    modport sink (
        input  valid, op, irq_number, poll_interval, poll_enable,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/pitt_out_if.sv =====
`default_nettype none

interface pitt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] fired_irq;
    logic [1:0]  status;
    logic        last;

    modport source (
        output valid, kind, fired_irq, status, last,
        input  ready
    );
    modport sink (
        input  valid, kind, fired_irq, status, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/pitt_cell.sv =====
`default_nettype none

module pitt_cell (
    input  wire                 i_clk,
    input  pitt_pkg::t_cell_ctl i_ctl,
    input  pitt_pkg::t_entry    i_shift_in,
    input  pitt_pkg::t_entry    i_load_in,
    output pitt_pkg::t_entry    o_entry
);

    pitt_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_load_in;
        end else if (i_ctl.shift) begin
            r_entry <= i_shift_in;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== rtl/core/polled_interrupt_timer_table.sv =====
// Add: the request loads the next free cell, then the flush state registers the status result.
// Polling tick with polling enabled on a nonempty table: one rotation of the cell chain, then
// the flush state registers the final result; otherwise the tick goes straight to the flush state.
// Delete: one rotation to find the number, and a further rotation to replace it when found.
// A fired interrupt or a final result that the result port stalls holds the rotation or the flush.
// One request at a time; synchronous active-low reset clears the count and control state only.
`default_nettype none

module polled_interrupt_timer_table (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pitt_in_if.sink      i_in,
    pitt_out_if.source   o_out
);

    localparam int unsigned DEPTH = pitt_pkg::TABLE_DEPTH;
    localparam int unsigned CW    = pitt_pkg::CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_REPL  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]       r_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_step;
    logic             r_hit;
    logic [CW-1:0]    r_hit_ix;
    logic [15:0]      r_key;
    pitt_pkg::t_entry r_hold;
    logic [1:0]       r_pend_kind;
    logic [15:0]      r_pend_irq;
    logic [1:0]       r_pend_status;
    logic             r_out_valid;
    logic [1:0]       r_out_kind;
    logic [15:0]      r_out_irq;
    logic [1:0]       r_out_status;
    logic             r_out_last;

    pitt_pkg::t_entry    w_entry [DEPTH];
    pitt_pkg::t_entry    w_head;
    pitt_pkg::t_entry    w_tail;
    pitt_pkg::t_entry    w_load;
    pitt_pkg::t_cell_ctl w_ctl [DEPTH];

    logic w_in_fire;
    logic w_out_free;
    logic w_live;
    logic w_step_end;
    logic w_has_room;
    logic w_add;
    logic w_match;
    logic w_tick_fire;
    logic w_stall;
    logic w_shift;
    logic w_push;

    assign w_head      = w_entry[0];
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_live      = r_step < r_count;
    assign w_step_end  = r_step == CW'(DEPTH - 1);
    assign w_has_room  = r_count < CW'(DEPTH);
    assign w_add       = w_in_fire && (i_in.op == pitt_pkg::OP_ADD) && w_has_room;
    assign w_match     = (r_state == S_FIND) && w_live && !r_hit && (w_head.irq == r_key);
    assign w_tick_fire = (r_state == S_WALK) && w_live && (w_head.countdown <= 16'd1);
    assign w_stall     = w_tick_fire && !w_out_free;
    assign w_shift     = ((r_state == S_WALK) && !w_stall) || (r_state == S_FIND)
                         || (r_state == S_REPL);
    assign w_push      = ((r_state == S_FLUSH) || w_tick_fire) && w_out_free;

    assign w_load.irq       = i_in.irq_number;
    assign w_load.interval  = i_in.poll_interval;
    assign w_load.countdown = i_in.poll_interval;

    always_comb begin
        w_tail = w_head;
        if ((r_state == S_WALK) && w_live) begin
            if (w_head.countdown <= 16'd1) begin
                w_tail.countdown = w_head.interval;
            end else begin
                w_tail.countdown = w_head.countdown - 16'd1;
            end
        end else if ((r_state == S_REPL) && (r_step == r_hit_ix)) begin
            w_tail = r_hold;
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        assign w_ctl[k].shift = w_shift;
        assign w_ctl[k].load  = w_add && (r_count == CW'(k));

        if (k == DEPTH - 1) begin : g_tail
            pitt_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[k]),
                .i_shift_in (w_tail),
                .i_load_in  (w_load),
                .o_entry    (w_entry[k])
            );
        end else begin : g_body
            pitt_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[k]),
                .i_shift_in (w_entry[k+1]),
                .i_load_in  (w_load),
                .o_entry    (w_entry[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    r_hit  <= 1'b0;
                    if (w_in_fire) begin
                        unique case (i_in.op)
                            pitt_pkg::OP_ADD: begin
                                if (w_has_room) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= S_FLUSH;
                            end
                            pitt_pkg::OP_DEL: begin
                                r_state <= S_FIND;
                            end
                            pitt_pkg::OP_TICK: begin
                                if (i_in.poll_enable && (r_count != '0)) begin
                                    r_state <= S_WALK;
                                end else begin
                                    r_state <= S_FLUSH;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (!w_stall) begin
                        r_step <= r_step + CW'(1);
                        if (w_step_end) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FIND: begin
                    if (w_match) begin
                        r_hit <= 1'b1;
                    end
                    if (w_step_end) begin
                        r_step  <= '0;
                        r_state <= (r_hit || w_match) ? S_REPL : S_FLUSH;
                    end else begin
                        r_step <= r_step + CW'(1);
                    end
                end
                S_REPL: begin
                    r_step <= r_step + CW'(1);
                    if (w_step_end) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_in_fire) begin
            r_key <= i_in.irq_number;
            if (i_in.op == pitt_pkg::OP_ADD) begin
                r_pend_kind   <= pitt_pkg::KIND_STATUS;
                r_pend_irq    <= i_in.irq_number;
                r_pend_status <= w_has_room ? pitt_pkg::ST_OK : pitt_pkg::ST_FULL;
            end else if (i_in.op == pitt_pkg::OP_TICK) begin
                r_pend_kind   <= pitt_pkg::KIND_IPI;
                r_pend_irq    <= '0;
                r_pend_status <= pitt_pkg::ST_OK;
            end
        end

        if (w_match) begin
            r_hit_ix <= r_step;
        end
        if ((r_state == S_FIND) && w_live && ((r_step + CW'(1)) == r_count)) begin
            r_hold <= w_head;
        end
        if ((r_state == S_FIND) && w_step_end) begin
            r_pend_kind   <= pitt_pkg::KIND_STATUS;
            r_pend_irq    <= r_key;
            r_pend_status <= (r_hit || w_match) ? pitt_pkg::ST_OK : pitt_pkg::ST_NOTFOUND;
        end

        if (w_push) begin
            r_out_kind   <= r_pend_kind;
            r_out_irq    <= r_pend_irq;
            r_out_status <= r_pend_status;
            r_out_last   <= (r_state == S_FLUSH);
        end
        if (w_tick_fire && w_out_free) begin
            r_pend_kind   <= pitt_pkg::KIND_FIRED;
            r_pend_irq    <= w_head.irq;
            r_pend_status <= pitt_pkg::ST_OK;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_out_kind;
    assign o_out.fired_irq = r_out_irq;
    assign o_out.status    = r_out_status;
    assign o_out.last      = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) && w_out_free |=> (r_state == S_IDLE) && r_out_valid
        && r_out_last)
        else $error("Final result was not delivered on leaving flush.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> r_out_valid && (r_state == S_WALK) && $stable(r_step))
        else $error("Walk advanced while the result register was blocked.");

endmodule

`default_nettype wire

// ===== test/polled_interrupt_timer_table_tb.sv =====
module polled_interrupt_timer_table_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] CHK_MODEL = 2'd0;
    localparam logic [1:0] CHK_NONE  = 2'd1;
    localparam logic [1:0] CHK_TYPED = 2'd2;

    localparam int unsigned CYCLE_LIMIT    = 1000000;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned ITEMS_PER_PHASE = 76;
    localparam int unsigned NUM_PHASES     = 5;
    localparam int unsigned DRAIN_CYCLES   = 2 * pitt_pkg::TABLE_DEPTH + 8;
    localparam int unsigned MAX_REPORTS    = 200;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] irq;
        logic [15:0] interval;
        logic        enable;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] irq;
        logic [1:0]  status;
        logic        last;
    } t_result;

    typedef struct packed {
        t_req        req;
        logic [1:0]  check;
        t_result     typed;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pitt_in_if  in_if ();
    pitt_out_if out_if ();

    polled_interrupt_timer_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [15:0] tbl_irq       [pitt_pkg::TABLE_DEPTH];
    logic [15:0] tbl_interval  [pitt_pkg::TABLE_DEPTH];
    logic [15:0] tbl_countdown [pitt_pkg::TABLE_DEPTH];
    int          tbl_count;

    t_result     step_results[$];
    t_result     awaited_results[$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        holdoff_pending = 1'b0;
    logic        fill_mode = 1'b1;

    t_dir_row    dir_rows [0:24];

    function automatic void add_result(input logic [1:0] kind, input logic [15:0] irq,
                                       input logic [1:0] status);
        step_results.push_back('{kind, irq, status, 1'b0});
    endfunction

    // Applies one request to the local copy of the table and collects its results.
    function automatic void step_timer_table(input t_req r);
        int hit;
        int unsigned k;
        hit = -1;
        step_results.delete();
        case (r.op)
            pitt_pkg::OP_ADD: begin
                if (tbl_count >= pitt_pkg::TABLE_DEPTH) begin
                    add_result(pitt_pkg::KIND_STATUS, r.irq, pitt_pkg::ST_FULL);
                end else begin
                    tbl_irq[tbl_count]       = r.irq;
                    tbl_interval[tbl_count]  = r.interval;
                    tbl_countdown[tbl_count] = r.interval;
                    tbl_count++;
                    add_result(pitt_pkg::KIND_STATUS, r.irq, pitt_pkg::ST_OK);
                end
            end
            pitt_pkg::OP_DEL: begin
                for (k = 0; k < tbl_count; k++) begin
                    if (hit < 0 && tbl_irq[k] == r.irq) begin
                        hit = k;
                    end
                end
                if (hit >= 0) begin
                    tbl_irq[hit]       = tbl_irq[tbl_count - 1];
                    tbl_interval[hit]  = tbl_interval[tbl_count - 1];
                    tbl_countdown[hit] = tbl_countdown[tbl_count - 1];
                    tbl_count--;
                    add_result(pitt_pkg::KIND_STATUS, r.irq, pitt_pkg::ST_OK);
                end else begin
                    add_result(pitt_pkg::KIND_STATUS, r.irq, pitt_pkg::ST_NOTFOUND);
                end
            end
            pitt_pkg::OP_TICK: begin
                add_result(pitt_pkg::KIND_IPI, 16'h0000, pitt_pkg::ST_OK);
                if (r.enable) begin
                    for (k = 0; k < tbl_count; k++) begin
                        if (tbl_countdown[k] <= 16'd1) begin
                            tbl_countdown[k] = tbl_interval[k];
                            add_result(pitt_pkg::KIND_FIRED, tbl_irq[k], pitt_pkg::ST_OK);
                        end else begin
                            tbl_countdown[k] = tbl_countdown[k] - 16'd1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic t_req random_request();
        t_req r;
        int unsigned pick;
        pick       = $urandom_range(0, 99);
        r.op       = pitt_pkg::OP_TICK;
        r.irq      = 16'($urandom);
        r.interval = 16'($urandom);
        r.enable   = ($urandom_range(0, 5) != 0);
        if (pick < 2) begin
            r.op = OP_UNUSED;
        end else if (pick < (fill_mode ? 50 : 20)) begin
            r.op = pitt_pkg::OP_ADD;
            if ($urandom_range(0, 3) != 0) begin
                r.irq = 16'($urandom_range(0, 15));
            end
            case ($urandom_range(0, 9))
                0: r.interval = 16'hFFFF;
                1: r.interval = 16'($urandom);
                2, 3: r.interval = 16'($urandom_range(5, 40));
                default: r.interval = 16'($urandom_range(0, 4));
            endcase
        end else if (pick < 70) begin
            r.op = pitt_pkg::OP_DEL;
            if (tbl_count > 0 && $urandom_range(0, 4) != 0) begin
                r.irq = tbl_irq[$urandom_range(0, tbl_count - 1)];
            end else if ($urandom_range(0, 1) != 0) begin
                r.irq = 16'($urandom_range(0, 15));
            end
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input t_req r, input logic [1:0] check, input t_result typed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.op            <= r.op;
        in_if.irq_number    <= r.irq;
        in_if.poll_interval <= r.interval;
        in_if.poll_enable   <= r.enable;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        step_timer_table(r);
        if (check == CHK_MODEL) begin
            foreach (step_results[k]) begin
                awaited_results.push_back(step_results[k]);
            end
        end else if (check == CHK_TYPED) begin
            awaited_results.push_back(typed);
        end
        @(negedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (awaited_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result, expected none, actual %h %h %h %b",
                             $time, out_if.kind, out_if.fired_irq, out_if.status,
                             out_if.last);
                end
            end else begin
                want = awaited_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(out_if.kind));
                check_field("fired_irq", want.irq, out_if.fired_irq);
                check_field("status", 16'(want.status), 16'(out_if.status));
                check_field("last", 16'(want.last), 16'(out_if.last));
            end
        end
    end

    initial begin : result_receiver
        int unsigned holdoff_left;
        holdoff_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_pending) begin
                holdoff_pending = 1'b0;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_req        r;
        t_result     no_result;
        int unsigned sent;
        int unsigned ph;
        no_result = '0;
        tbl_count = 0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.op = pitt_pkg::OP_ADD;
        in_if.irq_number = 16'h0000;
        in_if.poll_interval = 16'h0000;
        in_if.poll_enable = 1'b0;

        dir_rows = '{
            '{'{pitt_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1}, CHK_TYPED,
              '{pitt_pkg::KIND_IPI, 16'h0000, pitt_pkg::ST_OK, 1'b1}},
            '{'{pitt_pkg::OP_DEL, 16'h1234, 16'h0000, 1'b0}, CHK_TYPED,
              '{pitt_pkg::KIND_STATUS, 16'h1234, pitt_pkg::ST_NOTFOUND, 1'b1}},
            '{'{pitt_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 1'b0}, CHK_TYPED,
              '{pitt_pkg::KIND_STATUS, 16'hFFFF, pitt_pkg::ST_OK, 1'b1}},
            '{'{pitt_pkg::OP_ADD, 16'h0000, 16'h0000, 1'b1}, CHK_TYPED,
              '{pitt_pkg::KIND_STATUS, 16'h0000, pitt_pkg::ST_OK, 1'b1}},
            '{'{pitt_pkg::OP_ADD, 16'h0007, 16'h0001, 1'b0}, CHK_TYPED,
              '{pitt_pkg::KIND_STATUS, 16'h0007, pitt_pkg::ST_OK, 1'b1}},
            '{'{pitt_pkg::OP_ADD, 16'h0007, 16'h0002, 1'b0}, CHK_TYPED,
              '{pitt_pkg::KIND_STATUS, 16'h0007, pitt_pkg::ST_OK, 1'b1}},
            '{'{pitt_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 1'b0}, CHK_TYPED,
              '{pitt_pkg::KIND_IPI, 16'h0000, pitt_pkg::ST_OK, 1'b1}},
            '{'{pitt_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1}, CHK_MODEL, no_result},
            '{'{OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1}, CHK_NONE, no_result},
            '{'{pitt_pkg::OP_DEL, 16'h0007, 16'h0000, 1'b0}, CHK_TYPED,
              '{pitt_pkg::KIND_STATUS, 16'h0007, pitt_pkg::ST_OK, 1'b1}},
            '{'{pitt_pkg::OP_ADD, 16'h0100, 16'h0000, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h0101, 16'h0001, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h0102, 16'h0000, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h0103, 16'h0002, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h0104, 16'h0000, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h0105, 16'h0001, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h0106, 16'h0000, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h0107, 16'h0003, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h0108, 16'h0000, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h0109, 16'h8000, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h010A, 16'h0000, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h010B, 16'h0001, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'h010C, 16'h0000, 1'b0}, CHK_MODEL, no_result},
            '{'{pitt_pkg::OP_ADD, 16'hAAAA, 16'h5555, 1'b0}, CHK_TYPED,
              '{pitt_pkg::KIND_STATUS, 16'hAAAA, pitt_pkg::ST_FULL, 1'b1}},
            '{'{pitt_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1}, CHK_MODEL, no_result}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].req, dir_rows[k].check, dir_rows[k].typed);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: begin
                    send_idle_pct = 76;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 76;
                end
                3: begin
                    send_idle_pct = 10;
                    recv_stall_pct = 10;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (ph == NUM_PHASES - 1) begin
                // The result port holds off while requests keep coming.
                @(posedge i_clk);
                holdoff_pending = 1'b1;
                @(negedge i_clk);
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (tbl_count >= pitt_pkg::TABLE_DEPTH) begin
                    fill_mode = 1'b0;
                end else if (tbl_count <= 2) begin
                    fill_mode = 1'b1;
                end
                r = random_request();
                send_request(r, CHK_MODEL, no_result);
                if (r.op != OP_UNUSED) begin
                    sent++;
                end
            end
        end

        in_if.valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== polled_interrupt_timer_table.f =====
rtl/core/pitt_pkg.sv
rtl/core/pitt_in_if.sv
rtl/core/pitt_out_if.sv
rtl/core/pitt_cell.sv
rtl/core/polled_interrupt_timer_table.sv
test/polled_interrupt_timer_table_tb.sv
